### rtl/core/dtr_pkg.sv
// ----------------------------------------------------------------------------
// dtr_pkg
// Shared types and constants for the decode time estimator: timestamp width,
// sorted store sizing, sequencer states, shared unit opcodes, store commands.
// ----------------------------------------------------------------------------
package dtr_pkg;

    localparam int TIME_BITS = 48;
    localparam int STORE_CAP = 32;
    localparam int IDX_W     = $clog2(STORE_CAP);
    localparam int CNT_W     = $clog2(STORE_CAP + 1);

    typedef logic [TIME_BITS-1:0] stamp_t;
    typedef logic [CNT_W-1:0]     count_t;
    typedef logic [IDX_W-1:0]     index_t;

    localparam count_t CAP_COUNT  = count_t'(STORE_CAP);
    localparam count_t ZERO_COUNT = count_t'(0);
    localparam count_t ONE_COUNT  = count_t'(1);

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DUP,
        ST_PEAK,
        ST_OFFS,
        ST_SCAN,
        ST_INS,
        ST_CHK,
        ST_GAP,
        ST_CMP,
        ST_ADD,
        ST_DONE
    } state_t;

    // shared add/subtract unit operations
    typedef enum logic {
        ALU_SUB,
        ALU_ADD
    } alu_op_t;

    // one command per cycle to the sorted store
    typedef struct packed {
        logic   drop;
        logic   insert;
        index_t pos;
        stamp_t value;
    } store_cmd_t;

endpackage

### rtl/core/decode_time_from_reorder_core.sv
// ----------------------------------------------------------------------------
// decode_time_from_reorder_core
// Estimates a decode timestamp per video frame from its presentation time.
//
// Input stream: one pts per transfer on s_tdata. Output stream: one dts per
// input on m_tdata, with m_tuser set when the value came from the reorder
// sorter, depth-one pass-through or reuse of the last dts, clear when it
// falls back to pts. Results leave in input order, one per input.
// A small sequencer drives one shared 48-bit add/subtract unit: it checks for
// a repeated pts, tracks pts peaks to learn the reorder depth and offset,
// scans the sorted store one entry per cycle to find the insert slot, then
// computes the gap, the offset cap and the final sum in turn.
// The store scan through the shared unit is the longest step for an item and
// grows with the store fill. s_tready is high only while the sequencer waits
// for an item.
// The result sits in an output register, so a new item is taken while the
// previous result waits; if the receiver stalls on that result, the next
// item finishes and holds in the sequencer until the register frees.
// Reset (aresetn low, synchronous) empties the store, forgets the depth,
// offset and peak history and clears the output valid.
// ----------------------------------------------------------------------------
module decode_time_from_reorder_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dtr_pkg::TIME_BITS-1:0] s_tdata,   // [47:0] pts_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dtr_pkg::TIME_BITS-1:0] m_tdata,   // [47:0] dts_out
    output logic [0:0]                    m_tuser    // [0] from_sorter
);
    import dtr_pkg::*;

    state_t     state_reg, state_next;
    stamp_t     pts_reg, pts_next;
    stamp_t     prev_pts_reg, prev_pts_next;
    stamp_t     prev_dts_reg, prev_dts_next;
    count_t     depth_reg, depth_next;
    logic       first_seen_reg, first_seen_next;
    count_t     fsp_reg, fsp_next;
    stamp_t     peak_reg, peak_next;
    stamp_t     offset_reg, offset_next;
    count_t     idx_reg, idx_next;
    count_t     pos_reg, pos_next;
    stamp_t     gap_reg, gap_next;
    stamp_t     res_dts_reg, res_dts_next;
    logic       res_flag_reg, res_flag_next;
    stamp_t     out_dts_reg, out_dts_next;
    logic       out_flag_reg, out_flag_next;
    logic       out_valid_reg, out_valid_next;

    alu_op_t    alu_op;
    stamp_t     alu_a, alu_b, alu_res;
    logic       alu_borrow, alu_equal;
    store_cmd_t cmd;
    index_t     rd_idx;
    stamp_t     rd_data;
    count_t     store_count;

    logic       s_xfer;
    logic       can_load;
    logic       store_full;
    logic       emit_ready;
    count_t     fsp_inc;

    dtr_alu u_alu (
        .op     (alu_op),
        .op_a   (alu_a),
        .op_b   (alu_b),
        .result (alu_res),
        .borrow (alu_borrow),
        .equal  (alu_equal)
    );

    dtr_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .count   (store_count)
    );

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_xfer     = s_tvalid && s_tready;
    assign can_load   = !out_valid_reg || m_tready;
    assign store_full = (store_count == CAP_COUNT);
    assign emit_ready = (depth_reg > ONE_COUNT) && (store_count > depth_reg);
    assign fsp_inc    = (fsp_reg < CAP_COUNT) ? fsp_reg + ONE_COUNT : fsp_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) state_next = ST_DUP;
            end
            ST_DUP: begin
                if (alu_equal || depth_reg == ONE_COUNT) begin
                    state_next = ST_DONE;
                end else if (depth_reg == ZERO_COUNT) begin
                    state_next = ST_PEAK;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_PEAK: begin
                if (alu_borrow && fsp_reg != ZERO_COUNT && first_seen_reg) begin
                    state_next = ST_OFFS;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_OFFS: state_next = ST_SCAN;
            ST_SCAN: begin
                if (idx_reg == store_count) begin
                    state_next = ST_INS;
                end else if (alu_borrow) begin
                    state_next = ST_SCAN;
                end else if (alu_equal) begin
                    state_next = ST_CHK;
                end else begin
                    state_next = ST_INS;
                end
            end
            ST_INS: begin
                if (!store_full) state_next = ST_CHK;
            end
            ST_CHK: state_next = emit_ready ? ST_GAP : ST_DONE;
            ST_GAP: state_next = ST_CMP;
            ST_CMP: state_next = alu_borrow ? ST_DONE : ST_ADD;
            ST_ADD: state_next = ST_DONE;
            ST_DONE: begin
                if (can_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath control and register updates
    always_comb begin
        pts_next        = pts_reg;
        prev_pts_next   = prev_pts_reg;
        prev_dts_next   = prev_dts_reg;
        depth_next      = depth_reg;
        first_seen_next = first_seen_reg;
        fsp_next        = fsp_reg;
        peak_next       = peak_reg;
        offset_next     = offset_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        gap_next        = gap_reg;
        res_dts_next    = res_dts_reg;
        res_flag_next   = res_flag_reg;
        out_dts_next    = out_dts_reg;
        out_flag_next   = out_flag_reg;
        out_valid_next  = out_valid_reg;

        alu_op     = ALU_SUB;
        alu_a      = pts_reg;
        alu_b      = prev_pts_reg;
        rd_idx     = idx_reg[IDX_W-1:0];
        cmd.drop   = 1'b0;
        cmd.insert = 1'b0;
        cmd.pos    = pos_reg[IDX_W-1:0];
        cmd.value  = pts_reg;

        // output register drains on a transfer
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) pts_next = s_tdata;
            end
            // repeated pts check, depth-one pass-through
            ST_DUP: begin
                idx_next = ZERO_COUNT;
                if (alu_equal) begin
                    if (prev_dts_reg != '0) begin
                        res_dts_next  = prev_dts_reg;
                        res_flag_next = 1'b1;
                    end else begin
                        res_dts_next  = pts_reg;
                        res_flag_next = 1'b0;
                    end
                end else if (depth_reg == ONE_COUNT) begin
                    res_dts_next  = pts_reg;
                    res_flag_next = 1'b1;
                end
            end
            // rising peak tracking while depth is unknown
            ST_PEAK: begin
                alu_a = peak_reg;
                alu_b = pts_reg;
                if (alu_borrow) begin
                    if (!(fsp_reg != ZERO_COUNT && first_seen_reg)) begin
                        first_seen_next = first_seen_reg | (fsp_reg != ZERO_COUNT);
                        fsp_next        = ONE_COUNT;
                        peak_next       = pts_reg;
                    end
                end else begin
                    fsp_next = fsp_inc;
                end
            end
            // second peak: learn depth and half the peak gap
            ST_OFFS: begin
                alu_a           = pts_reg;
                alu_b           = peak_reg;
                offset_next     = alu_res >> 1;
                depth_next      = fsp_reg;
                first_seen_next = 1'b1;
                fsp_next        = ONE_COUNT;
                peak_next       = pts_reg;
            end
            // find first entry not below pts
            ST_SCAN: begin
                alu_a = rd_data;
                alu_b = pts_reg;
                if (idx_reg == store_count) begin
                    pos_next = idx_reg;
                end else if (alu_borrow) begin
                    idx_next = idx_reg + ONE_COUNT;
                end else if (!alu_equal) begin
                    pos_next = idx_reg;
                end
            end
            // make room when full, then insert
            ST_INS: begin
                if (store_full) begin
                    cmd.drop = 1'b1;
                    if (pos_reg != ZERO_COUNT) pos_next = pos_reg - ONE_COUNT;
                end else begin
                    cmd.insert = 1'b1;
                end
            end
            ST_CHK: begin
                if (!emit_ready) begin
                    res_dts_next  = pts_reg;
                    res_flag_next = 1'b0;
                end
            end
            // gap between pts and smallest entry
            ST_GAP: begin
                rd_idx   = '0;
                alu_a    = pts_reg;
                alu_b    = rd_data;
                gap_next = alu_res;
            end
            // offset cap check
            ST_CMP: begin
                alu_a = gap_reg;
                alu_b = offset_reg;
                if (alu_borrow) begin
                    res_dts_next  = pts_reg;
                    res_flag_next = 1'b1;
                    cmd.drop      = 1'b1;
                end
            end
            ST_ADD: begin
                rd_idx        = '0;
                alu_op        = ALU_ADD;
                alu_a         = rd_data;
                alu_b         = offset_reg;
                res_dts_next  = alu_res;
                res_flag_next = 1'b1;
                cmd.drop      = 1'b1;
            end
            // commit history and hand result to the output register
            ST_DONE: begin
                if (can_load) begin
                    out_dts_next   = res_dts_reg;
                    out_flag_next  = res_flag_reg;
                    out_valid_next = 1'b1;
                    prev_pts_next  = pts_reg;
                    if (res_flag_reg) prev_dts_next = res_dts_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // control and history state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            prev_pts_reg   <= '0;
            prev_dts_reg   <= '0;
            depth_reg      <= ZERO_COUNT;
            first_seen_reg <= 1'b0;
            fsp_reg        <= ZERO_COUNT;
            peak_reg       <= '0;
            offset_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            prev_pts_reg   <= prev_pts_next;
            prev_dts_reg   <= prev_dts_next;
            depth_reg      <= depth_next;
            first_seen_reg <= first_seen_next;
            fsp_reg        <= fsp_next;
            peak_reg       <= peak_next;
            offset_reg     <= offset_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // working payload
    always_ff @(posedge aclk) begin
        pts_reg      <= pts_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        gap_reg      <= gap_next;
        res_dts_reg  <= res_dts_next;
        res_flag_reg <= res_flag_next;
        out_dts_reg  <= out_dts_next;
        out_flag_reg <= out_flag_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_dts_reg;
    assign m_tuser[0] = out_flag_reg;

endmodule

### rtl/core/dtr_alu.sv
// ----------------------------------------------------------------------------
// dtr_alu
// Shared timestamp add/subtract unit; the borrow of a subtract serves as the
// less-than flag for the compares the sequencer does through this unit.
// ----------------------------------------------------------------------------
module dtr_alu (
    input  dtr_pkg::alu_op_t op,
    input  dtr_pkg::stamp_t  op_a,
    input  dtr_pkg::stamp_t  op_b,
    output dtr_pkg::stamp_t  result,
    output logic             borrow,
    output logic             equal
);
    import dtr_pkg::*;

    logic [TIME_BITS:0] sum_wide;

    // one wide adder, carry or borrow in the top bit
    always_comb begin
        case (op)
            ALU_ADD: sum_wide = {1'b0, op_a} + {1'b0, op_b};
            ALU_SUB: sum_wide = {1'b0, op_a} - {1'b0, op_b};
            default: sum_wide = {1'b0, op_a} - {1'b0, op_b};
        endcase
    end

    assign result = sum_wide[TIME_BITS-1:0];
    assign borrow = sum_wide[TIME_BITS];
    assign equal  = (op_a == op_b);

endmodule

### rtl/core/dtr_store.sv
// ----------------------------------------------------------------------------
// dtr_store
// Ascending sorted register store with a fill count. One read port chosen by
// the sequencer; per cycle either an insert at a given slot (upper entries
// move up one) or a drop of the smallest entry (all entries move down one).
// ----------------------------------------------------------------------------
module dtr_store (
    input  logic                aclk,
    input  logic                aresetn,
    input  dtr_pkg::store_cmd_t cmd,
    input  dtr_pkg::index_t     rd_idx,
    output dtr_pkg::stamp_t     rd_data,
    output dtr_pkg::count_t     count
);
    import dtr_pkg::*;

    stamp_t entries_reg  [STORE_CAP];
    stamp_t entries_next [STORE_CAP];
    count_t count_reg;
    count_t count_next;

    // per-entry shift for insert and drop
    always_comb begin
        for (int i = 0; i < STORE_CAP; i++) begin
            entries_next[i] = entries_reg[i];
            if (cmd.insert) begin
                if (index_t'(i) == cmd.pos) begin
                    entries_next[i] = cmd.value;
                end else if (index_t'(i) > cmd.pos) begin
                    entries_next[i] = entries_reg[(i == 0) ? 0 : i - 1];
                end
            end else if (cmd.drop) begin
                if (i < STORE_CAP - 1) begin
                    entries_next[i] = entries_reg[(i < STORE_CAP - 1) ? i + 1 : i];
                end
            end
        end
    end

    // fill count
    always_comb begin
        count_next = count_reg;
        if (cmd.insert) begin
            count_next = count_reg + ONE_COUNT;
        end else if (cmd.drop) begin
            count_next = count_reg - ONE_COUNT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= ZERO_COUNT;
        end else begin
            count_reg <= count_next;
        end
    end

    // entry payload, no reset
    always_ff @(posedge aclk) begin
        for (int i = 0; i < STORE_CAP; i++) begin
            entries_reg[i] <= entries_next[i];
        end
    end

    assign rd_data = entries_reg[rd_idx];
    assign count   = count_reg;

endmodule
